>>> design/rbu_pkg.sv
// Shared types and constants for the RGBA blend unit.
package rbu_pkg;

  localparam int CHANNEL_BITS_DEF = 8;
  localparam int MODE_BITS = 2;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_OVER = 2'd0,
    MODE_MUL  = 2'd1,
    MODE_ADD  = 2'd2,
    MODE_AVG  = 2'd3
  } rbu_mode_t;

  typedef struct packed {
    logic      vld;
    rbu_mode_t mode;
  } rbu_ctl_t;

endpackage

>>> design/rbu_front.sv
// Operand stages: weights, products and the divider operands for each lane.
module rbu_front #(
  parameter int CB = rbu_pkg::CHANNEL_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rbu_pkg::rbu_ctl_t            up_ctl,
  output logic                         up_ready,
  input  logic [3:0][CB-1:0]           bg,
  input  logic [3:0][CB-1:0]           fg,
  output rbu_pkg::rbu_ctl_t            dn_ctl,
  input  logic                         dn_ready,
  output logic [2:0][3*CB-1:0]         dn_num,
  output logic [2:0][2*CB-1:0]         dn_dvs,
  output logic [3:0][CB-1:0]           dn_byp
);
  import rbu_pkg::*;

  localparam int DW = 2 * CB;
  localparam int NW = 3 * CB;
  localparam logic [CB-1:0] MAXV = '1;
  localparam logic [CB-1:0] HALF = CB'((1 << (CB - 1)) - 1);

  rbu_ctl_t             s1_ctl_r, s2_ctl_r, s3_ctl_r;
  logic                 s1_rdy, s2_rdy, s3_rdy;
  logic [DW-1:0]        s1_wfg_r, s1_wbg_r, s1_wfg_nxt, s1_wbg_nxt;
  logic [3:0][DW-1:0]   s1_prod_r, s1_prod_nxt;
  logic [3:0][CB-1:0]   s1_byp_r, s1_byp_nxt;
  logic [2:0][CB-1:0]   s1_fg_r, s1_bg_r;
  logic [CB-1:0]        s1_fa_r;
  logic [DW-1:0]        s2_den_r, s2_wbg_r;
  logic [2:0][NW-1:0]   s2_pfg_r, s2_pbg_r;
  logic [3:0][DW-1:0]   s2_prod_r;
  logic [3:0][CB-1:0]   s2_byp_r;
  logic [CB-1:0]        s2_fa_r;
  logic [2:0][NW-1:0]   s3_num_r, s3_num_nxt;
  logic [2:0][DW-1:0]   s3_dvs_r, s3_dvs_nxt;
  logic [3:0][CB-1:0]   s3_byp_r, s3_byp_nxt;
  logic [DW:0]          s3_anum;
  logic [CB-1:0]        s3_aquo;
  logic [CB:0]          sum [3];

  assign s3_rdy   = !s3_ctl_r.vld || dn_ready;
  assign s2_rdy   = !s2_ctl_r.vld || s3_rdy;
  assign s1_rdy   = !s1_ctl_r.vld || s2_rdy;
  assign up_ready = s1_rdy;

  always_comb begin
    s1_wfg_nxt = {fg[3], {CB{1'b0}}} - DW'(fg[3]);
    s1_wbg_nxt = DW'(bg[3]) * DW'(MAXV - fg[3]);
    for (int i = 0; i < 4; i++) begin
      s1_prod_nxt[i] = DW'(bg[i]) * DW'(fg[i]);
    end
    for (int i = 0; i < 3; i++) begin
      sum[i] = {1'b0, bg[i]} + {1'b0, fg[i]};
      if (up_ctl.mode == MODE_ADD) begin
        s1_byp_nxt[i] = sum[i][CB] ? MAXV : sum[i][CB-1:0];
      end else begin
        s1_byp_nxt[i] = sum[i][CB:1];
      end
    end
    s1_byp_nxt[3] = (bg[3] > fg[3]) ? bg[3] : fg[3];
  end

  // The alpha lane divides by the full-scale value with a reciprocal add and shift.
  always_comb begin
    s3_byp_nxt = s2_byp_r;
    case (s2_ctl_r.mode)
      MODE_OVER: begin
        for (int i = 0; i < 3; i++) begin
          if (s2_den_r == '0) begin
            s3_num_nxt[i] = '0;
            s3_dvs_nxt[i] = DW'(1);
          end else begin
            s3_num_nxt[i] = s2_pfg_r[i] + s2_pbg_r[i] + NW'(s2_den_r >> 1);
            s3_dvs_nxt[i] = s2_den_r;
          end
        end
        s3_anum = {1'b0, s2_wbg_r} + (DW+1)'(HALF);
      end
      default: begin
        for (int i = 0; i < 3; i++) begin
          s3_num_nxt[i] = NW'(s2_prod_r[i]) + NW'(HALF);
          s3_dvs_nxt[i] = DW'(MAXV);
        end
        s3_anum = {1'b0, s2_prod_r[3]} + (DW+1)'(HALF);
      end
    endcase
    s3_aquo = CB'((s3_anum + (s3_anum >> CB) + (DW+1)'(1)) >> CB);
    if (s2_ctl_r.mode == MODE_OVER) begin
      s3_byp_nxt[3] = s3_aquo + s2_fa_r;
    end else if (s2_ctl_r.mode == MODE_MUL) begin
      s3_byp_nxt[3] = s3_aquo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
      s3_ctl_r <= '0;
    end else begin
      if (s1_rdy) s1_ctl_r <= up_ctl;
      if (s2_rdy) s2_ctl_r <= s1_ctl_r;
      if (s3_rdy) s3_ctl_r <= s2_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      s1_wfg_r  <= s1_wfg_nxt;
      s1_wbg_r  <= s1_wbg_nxt;
      s1_prod_r <= s1_prod_nxt;
      s1_byp_r  <= s1_byp_nxt;
      s1_fg_r   <= fg[2:0];
      s1_bg_r   <= bg[2:0];
      s1_fa_r   <= fg[3];
    end
    if (s2_rdy) begin
      s2_den_r  <= s1_wfg_r + s1_wbg_r;
      s2_wbg_r  <= s1_wbg_r;
      for (int i = 0; i < 3; i++) begin
        s2_pfg_r[i] <= NW'(s1_fg_r[i]) * NW'(s1_wfg_r);
        s2_pbg_r[i] <= NW'(s1_bg_r[i]) * NW'(s1_wbg_r);
      end
      s2_prod_r <= s1_prod_r;
      s2_byp_r  <= s1_byp_r;
      s2_fa_r   <= s1_fa_r;
    end
    if (s3_rdy) begin
      s3_num_r <= s3_num_nxt;
      s3_dvs_r <= s3_dvs_nxt;
      s3_byp_r <= s3_byp_nxt;
    end
  end

  assign dn_ctl = s3_ctl_r;
  assign dn_num = s3_num_r;
  assign dn_dvs = s3_dvs_r;
  assign dn_byp = s3_byp_r;

endmodule

>>> design/rbu_div_stage.sv
// One restoring division step for the three color lanes, producing one quotient bit.
module rbu_div_stage #(
  parameter int CB  = rbu_pkg::CHANNEL_BITS_DEF,
  parameter int BIT = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rbu_pkg::rbu_ctl_t    up_ctl,
  output logic                 up_ready,
  input  logic [2:0][3*CB-1:0] up_rem,
  input  logic [2:0][2*CB-1:0] up_dvs,
  input  logic [2:0][CB-1:0]   up_quo,
  input  logic [3:0][CB-1:0]   up_byp,
  output rbu_pkg::rbu_ctl_t    dn_ctl,
  input  logic                 dn_ready,
  output logic [2:0][3*CB-1:0] dn_rem,
  output logic [2:0][2*CB-1:0] dn_dvs,
  output logic [2:0][CB-1:0]   dn_quo,
  output logic [3:0][CB-1:0]   dn_byp
);
  import rbu_pkg::*;

  localparam int NW = 3 * CB;

  rbu_ctl_t           ctl_r;
  logic               rdy;
  logic [2:0][NW-1:0] rem_r, rem_nxt;
  logic [2:0][CB-1:0] quo_r, quo_nxt;
  logic [2:0][2*CB-1:0] dvs_r;
  logic [3:0][CB-1:0] byp_r;
  logic [NW-1:0]      shd [3];

  assign rdy      = !ctl_r.vld || dn_ready;
  assign up_ready = rdy;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shd[i]     = NW'(up_dvs[i]) << BIT;
      rem_nxt[i] = up_rem[i];
      quo_nxt[i] = up_quo[i];
      if (up_rem[i] >= shd[i]) begin
        rem_nxt[i]      = up_rem[i] - shd[i];
        quo_nxt[i][BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (rdy) begin
      ctl_r <= up_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      dvs_r <= up_dvs;
      byp_r <= up_byp;
    end
  end

  assign dn_ctl = ctl_r;
  assign dn_rem = rem_r;
  assign dn_dvs = dvs_r;
  assign dn_quo = quo_r;
  assign dn_byp = byp_r;

endmodule

>>> design/rbu_out.sv
// Output register: picks the quotient or the direct result for each channel.
module rbu_out #(
  parameter int CB = rbu_pkg::CHANNEL_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rbu_pkg::rbu_ctl_t  up_ctl,
  output logic               up_ready,
  input  logic [2:0][CB-1:0] up_quo,
  input  logic [3:0][CB-1:0] up_byp,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0][CB-1:0] pix
);
  import rbu_pkg::*;

  logic               vld_r;
  logic               rdy;
  logic [3:0][CB-1:0] pix_r, pix_nxt;

  assign rdy      = !vld_r || out_ready;
  assign up_ready = rdy;

  always_comb begin
    case (up_ctl.mode)
      MODE_OVER, MODE_MUL: begin
        pix_nxt[2:0] = up_quo;
        pix_nxt[3]   = up_byp[3];
      end
      default: begin
        pix_nxt = up_byp;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy) begin
      vld_r <= up_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy) begin
      pix_r <= pix_nxt;
    end
  end

  assign out_valid = vld_r;
  assign pix       = pix_r;

endmodule

>>> design/rgba_blend_unit.sv
// Top level of the RGBA blend unit: operand stages, divider chain and output register.
//
//   channel   handshake                 beat contents
//   in        in_valid / in_ready       background and foreground RGBA pixel
//   out       out_valid / out_ready     blended RGBA pixel
//   cfg       cfg_valid / cfg_ready     blend mode register
//
// A pixel passes from input to output through three operand stages, one restoring
// division stage per quotient bit, and the output register. One beat is accepted
// every cycle while the output drains.
// Reset clears the valid bits of every stage and sets the blend mode to alpha over.
// A stall holds each occupied stage, and empty stages keep filling behind it.
module rgba_blend_unit #(
  parameter int CHANNEL_BITS = rbu_pkg::CHANNEL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rbu_pkg::MODE_BITS-1:0] cfg_blend_mode,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [CHANNEL_BITS-1:0]       in_bg_red,
  input  logic [CHANNEL_BITS-1:0]       in_bg_green,
  input  logic [CHANNEL_BITS-1:0]       in_bg_blue,
  input  logic [CHANNEL_BITS-1:0]       in_bg_alpha,
  input  logic [CHANNEL_BITS-1:0]       in_fg_red,
  input  logic [CHANNEL_BITS-1:0]       in_fg_green,
  input  logic [CHANNEL_BITS-1:0]       in_fg_blue,
  input  logic [CHANNEL_BITS-1:0]       in_fg_alpha,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [CHANNEL_BITS-1:0]       out_red,
  output logic [CHANNEL_BITS-1:0]       out_green,
  output logic [CHANNEL_BITS-1:0]       out_blue,
  output logic [CHANNEL_BITS-1:0]       out_alpha
);
  import rbu_pkg::*;

  localparam int CB = CHANNEL_BITS;
  localparam int NW = 3 * CB;
  localparam int DW = 2 * CB;

  rbu_mode_t                mode_r;
  rbu_ctl_t                 in_ctl;
  logic [3:0][CB-1:0]       bg, fg, pix;

  rbu_ctl_t                 div_ctl [CB+1];
  logic [CB:0]              div_rdy;
  logic [CB:0][2:0][NW-1:0] div_rem;
  logic [CB:0][2:0][DW-1:0] div_dvs;
  logic [CB:0][2:0][CB-1:0] div_quo;
  logic [CB:0][3:0][CB-1:0] div_byp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_OVER;
    end else if (cfg_valid) begin
      mode_r <= rbu_mode_t'(cfg_blend_mode);
    end
  end

  assign in_ctl.vld  = in_valid;
  assign in_ctl.mode = mode_r;
  assign bg = {in_bg_alpha, in_bg_blue, in_bg_green, in_bg_red};
  assign fg = {in_fg_alpha, in_fg_blue, in_fg_green, in_fg_red};

  rbu_front #(.CB(CB)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_ctl   (in_ctl),
    .up_ready (in_ready),
    .bg       (bg),
    .fg       (fg),
    .dn_ctl   (div_ctl[0]),
    .dn_ready (div_rdy[0]),
    .dn_num   (div_rem[0]),
    .dn_dvs   (div_dvs[0]),
    .dn_byp   (div_byp[0])
  );

  assign div_quo[0] = '0;

  for (genvar j = 0; j < CB; j++) begin : g_div
    rbu_div_stage #(.CB(CB), .BIT(CB - 1 - j)) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_ctl   (div_ctl[j]),
      .up_ready (div_rdy[j]),
      .up_rem   (div_rem[j]),
      .up_dvs   (div_dvs[j]),
      .up_quo   (div_quo[j]),
      .up_byp   (div_byp[j]),
      .dn_ctl   (div_ctl[j+1]),
      .dn_ready (div_rdy[j+1]),
      .dn_rem   (div_rem[j+1]),
      .dn_dvs   (div_dvs[j+1]),
      .dn_quo   (div_quo[j+1]),
      .dn_byp   (div_byp[j+1])
    );
  end

  rbu_out #(.CB(CB)) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_ctl    (div_ctl[CB]),
    .up_ready  (div_rdy[CB]),
    .up_quo    (div_quo[CB]),
    .up_byp    (div_byp[CB]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pix       (pix)
  );

  assign out_red   = pix[0];
  assign out_green = pix[1];
  assign out_blue  = pix[2];
  assign out_alpha = pix[3];

endmodule
